// ----- design/ppsch_pkg.sv -----
// Package for the periodic poll scheduler: action, status, mode and
// controller state codes, the slot table entry layout and fixed widths.
// No dependencies.
package ppsch_pkg;

  localparam int TIME_W   = 48;
  localparam int PERIOD_W = 40;
  localparam int ORDER_W  = 32;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 4;

  localparam logic [PERIOD_W-1:0] WARN_RESET = 40'd1000000;
  localparam logic [TIME_W-1:0]   TIME_MAX   = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_SCHEDULE  = 2'd0,
    ACT_CANCEL    = 2'd1,
    ACT_POLL_DONE = 2'd2,
    ACT_CHECK     = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_SCHEDULED   = 4'd0,
    ST_IGNORED     = 4'd1,
    ST_REFUSED     = 4'd2,
    ST_CANCELLED   = 4'd3,
    ST_NOT_PRESENT = 4'd4,
    ST_POLL_NOW    = 4'd5,
    ST_WAIT        = 4'd6,
    ST_ALL_ACTIVE  = 4'd7,
    ST_EMPTY       = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SCHED  = 2'd1,
    MODE_ACTIVE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_EXEC,
    S_SCAN,
    S_TAIL,
    S_FIN
  } state_t;

  typedef struct packed {
    mode_t               mode;
    logic [ORDER_W-1:0]  order;
    logic [TIME_W-1:0]   deadline;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- design/ppsch_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ppsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/periodic_poll_scheduler.sv -----
// Periodic poll scheduler top level: controller and slot table datapath.
// Depends on ppsch_pkg and ppsch_ram.
//
// Usage:
//   Input word: in_action, in_device_slot, in_refresh_time, in_now_time and
//   in_elapsed_time are taken at a rising edge with start high and busy low.
//   Result word: out_status, out_poll_slot, out_wait_time and out_overrun
//   appear for one cycle with out_valid high; one result per input word.
//   The receiver cannot stall; results are registered and must be taken.
//   Config: cfg_warn_threshold is written when cfg_wr_en is high; write it
//   only while busy is low.
// Timing:
//   Schedule, cancel and poll_done pass through a read of the slot table,
//   modify/write and the output register, and a new word can be accepted
//   in the cycle the result is shown.
//   Check reads the slot table RAM one entry per cycle through its single
//   read port, followed by a compare tail and a decision cycle.
// Reset:
//   rst_n (synchronous, active low) marks every slot idle, clears the order
//   counter and loads the default warn threshold; no clearing pass is needed
//   since per-slot valid flops mask the RAM contents.
module periodic_poll_scheduler #(
  parameter int SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_action,
  input  logic [ppsch_pkg::SLOT_W-1:0]    in_device_slot,
  input  logic [ppsch_pkg::PERIOD_W-1:0]  in_refresh_time,
  input  logic [ppsch_pkg::TIME_W-1:0]    in_now_time,
  input  logic [ppsch_pkg::PERIOD_W-1:0]  in_elapsed_time,
  output logic                            out_valid,
  output logic [ppsch_pkg::STATUS_W-1:0]  out_status,
  output logic [ppsch_pkg::SLOT_W-1:0]    out_poll_slot,
  output logic [ppsch_pkg::TIME_W-1:0]    out_wait_time,
  output logic                            out_overrun,
  input  logic                            cfg_wr_en,
  input  logic [ppsch_pkg::PERIOD_W-1:0]  cfg_warn_threshold
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  ppsch_pkg::state_t state_r, state_nxt;

  ppsch_pkg::action_t                act_r;
  logic [ppsch_pkg::SLOT_W-1:0]      slot_r;
  logic [ppsch_pkg::PERIOD_W-1:0]    refresh_r;
  logic [ppsch_pkg::TIME_W-1:0]      now_r;
  logic [ppsch_pkg::PERIOD_W-1:0]    elapsed_r;

  logic [IW-1:0]                     cnt_r, cnt_nxt;
  logic                              cmp_vld_r;
  logic [IW-1:0]                     cmp_idx_r;
  logic                              found_r, found_nxt;
  logic                              any_act_r, any_act_nxt;
  logic [IW-1:0]                     best_idx_r, best_idx_nxt;
  logic [ppsch_pkg::TIME_W-1:0]      best_dl_r, best_dl_nxt;
  logic [ppsch_pkg::ORDER_W-1:0]     best_ord_r, best_ord_nxt;

  logic [SLOTS-1:0]                  vld_r, vld_nxt;
  logic [ppsch_pkg::ORDER_W-1:0]     next_order_r, next_order_nxt;
  logic [ppsch_pkg::PERIOD_W-1:0]    warn_r;

  logic                              out_valid_r, out_valid_nxt;
  ppsch_pkg::status_t                out_status_r, out_status_nxt;
  logic [ppsch_pkg::SLOT_W-1:0]      out_poll_slot_r, out_poll_slot_nxt;
  logic [ppsch_pkg::TIME_W-1:0]      out_wait_r, out_wait_nxt;
  logic                              out_overrun_r, out_overrun_nxt;

  logic                              accept;
  logic                              slot_ok;
  logic [IW-1:0]                     s_idx;
  logic [IW-1:0]                     rd_addr;
  logic [ppsch_pkg::ENTRY_W-1:0]     rd_data;
  ppsch_pkg::entry_t                 rd_q;
  ppsch_pkg::mode_t                  cur_mode;
  ppsch_pkg::mode_t                  cmp_mode;
  logic                              ram_we;
  logic [IW-1:0]                     ram_waddr;
  ppsch_pkg::entry_t                 ram_wentry;
  logic [ppsch_pkg::TIME_W:0]        dl_sum;
  logic [ppsch_pkg::TIME_W-1:0]      dl_new;
  logic                              over;
  logic                              better;

  assign busy      = (state_r != ppsch_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign slot_ok   = (int'(slot_r) < SLOTS);
  assign s_idx     = slot_ok ? IW'(slot_r) : '0;
  assign rd_addr   = (state_r == ppsch_pkg::S_SCAN) ? cnt_r : s_idx;
  assign rd_q      = ppsch_pkg::entry_t'(rd_data);

  assign dl_sum = {1'b0, now_r} + {{(ppsch_pkg::TIME_W + 1 - ppsch_pkg::PERIOD_W){1'b0}},
                                   refresh_r};
  assign dl_new = dl_sum[ppsch_pkg::TIME_W] ? ppsch_pkg::TIME_MAX
                                            : dl_sum[ppsch_pkg::TIME_W-1:0];
  assign over   = (elapsed_r > refresh_r) && ((elapsed_r - refresh_r) > warn_r);

  assign cur_mode = vld_r[s_idx] ? rd_q.mode : ppsch_pkg::MODE_IDLE;
  assign cmp_mode = vld_r[cmp_idx_r] ? rd_q.mode : ppsch_pkg::MODE_IDLE;
  assign better   = !found_r || (rd_q.deadline < best_dl_r) ||
                    ((rd_q.deadline == best_dl_r) && (rd_q.order < best_ord_r));

  ppsch_ram #(
    .WIDTH (ppsch_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppsch_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (ppsch_pkg::action_t'(in_action) == ppsch_pkg::ACT_CHECK) ?
                      ppsch_pkg::S_SCAN : ppsch_pkg::S_ISSUE;
        end
      end
      ppsch_pkg::S_ISSUE: state_nxt = ppsch_pkg::S_EXEC;
      ppsch_pkg::S_EXEC:  state_nxt = ppsch_pkg::S_IDLE;
      ppsch_pkg::S_SCAN: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = ppsch_pkg::S_TAIL;
        end
      end
      ppsch_pkg::S_TAIL:  state_nxt = ppsch_pkg::S_FIN;
      ppsch_pkg::S_FIN:   state_nxt = ppsch_pkg::S_IDLE;
      default:            state_nxt = ppsch_pkg::S_IDLE;
    endcase
  end

  // datapath and table updates
  always_comb begin
    cnt_nxt           = cnt_r;
    found_nxt         = found_r;
    any_act_nxt       = any_act_r;
    best_idx_nxt      = best_idx_r;
    best_dl_nxt       = best_dl_r;
    best_ord_nxt      = best_ord_r;
    vld_nxt           = vld_r;
    next_order_nxt    = next_order_r;
    out_valid_nxt     = 1'b0;
    out_status_nxt    = out_status_r;
    out_poll_slot_nxt = out_poll_slot_r;
    out_wait_nxt      = out_wait_r;
    out_overrun_nxt   = out_overrun_r;
    ram_we            = 1'b0;
    ram_waddr         = s_idx;
    ram_wentry        = '{mode: ppsch_pkg::MODE_SCHED, order: next_order_r, deadline: dl_new};

    case (state_r)
      ppsch_pkg::S_IDLE: begin
        cnt_nxt     = '0;
        found_nxt   = 1'b0;
        any_act_nxt = 1'b0;
      end
      ppsch_pkg::S_SCAN: begin
        cnt_nxt = cnt_r + IW'(1);
      end
      ppsch_pkg::S_EXEC: begin
        out_valid_nxt     = 1'b1;
        out_poll_slot_nxt = '0;
        out_wait_nxt      = '0;
        out_overrun_nxt   = 1'b0;
        out_status_nxt    = ppsch_pkg::ST_IGNORED;
        case (act_r)
          ppsch_pkg::ACT_SCHEDULE: begin
            if (!slot_ok || cur_mode != ppsch_pkg::MODE_IDLE) begin
              out_status_nxt = ppsch_pkg::ST_IGNORED;
            end else if (refresh_r == '0) begin
              out_status_nxt = ppsch_pkg::ST_REFUSED;
            end else begin
              ram_we          = 1'b1;
              vld_nxt[s_idx]  = 1'b1;
              next_order_nxt  = next_order_r + 32'd1;
              out_status_nxt  = ppsch_pkg::ST_SCHEDULED;
            end
          end
          ppsch_pkg::ACT_CANCEL: begin
            if (slot_ok && cur_mode != ppsch_pkg::MODE_IDLE) begin
              vld_nxt[s_idx] = 1'b0;
              out_status_nxt = ppsch_pkg::ST_CANCELLED;
            end else begin
              out_status_nxt = ppsch_pkg::ST_NOT_PRESENT;
            end
          end
          ppsch_pkg::ACT_POLL_DONE: begin
            out_overrun_nxt = over;
            if (!slot_ok || cur_mode != ppsch_pkg::MODE_ACTIVE) begin
              out_status_nxt = ppsch_pkg::ST_IGNORED;
            end else if (refresh_r == '0) begin
              vld_nxt[s_idx] = 1'b0;
              out_status_nxt = ppsch_pkg::ST_REFUSED;
            end else begin
              ram_we         = 1'b1;
              next_order_nxt = next_order_r + 32'd1;
              out_status_nxt = ppsch_pkg::ST_SCHEDULED;
            end
          end
          default: out_status_nxt = ppsch_pkg::ST_IGNORED;
        endcase
      end
      ppsch_pkg::S_FIN: begin
        out_valid_nxt     = 1'b1;
        out_poll_slot_nxt = '0;
        out_wait_nxt      = '0;
        out_overrun_nxt   = 1'b0;
        ram_waddr         = best_idx_r;
        ram_wentry        = '{mode: ppsch_pkg::MODE_ACTIVE, order: best_ord_r,
                              deadline: best_dl_r};
        if (!found_r) begin
          out_status_nxt = any_act_r ? ppsch_pkg::ST_ALL_ACTIVE : ppsch_pkg::ST_EMPTY;
        end else if (best_dl_r > now_r) begin
          out_status_nxt = ppsch_pkg::ST_WAIT;
          out_wait_nxt   = best_dl_r - now_r;
        end else begin
          ram_we            = 1'b1;
          out_status_nxt    = ppsch_pkg::ST_POLL_NOW;
          out_poll_slot_nxt = ppsch_pkg::SLOT_W'(best_idx_r);
        end
      end
      default: ;
    endcase

    // compare the entry read in the previous scan cycle
    if (cmp_vld_r) begin
      if (cmp_mode == ppsch_pkg::MODE_ACTIVE) begin
        any_act_nxt = 1'b1;
      end
      if (cmp_mode == ppsch_pkg::MODE_SCHED && better) begin
        found_nxt    = 1'b1;
        best_idx_nxt = cmp_idx_r;
        best_dl_nxt  = rd_q.deadline;
        best_ord_nxt = rd_q.order;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ppsch_pkg::S_IDLE;
      vld_r        <= '0;
      next_order_r <= '0;
      warn_r       <= ppsch_pkg::WARN_RESET;
      out_valid_r  <= 1'b0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      any_act_r    <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      vld_r        <= vld_nxt;
      next_order_r <= next_order_nxt;
      out_valid_r  <= out_valid_nxt;
      cmp_vld_r    <= (state_r == ppsch_pkg::S_SCAN);
      found_r      <= found_nxt;
      any_act_r    <= any_act_nxt;
      cnt_r        <= cnt_nxt;
      if (cfg_wr_en) begin
        warn_r <= cfg_warn_threshold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r     <= ppsch_pkg::action_t'(in_action);
      slot_r    <= in_device_slot;
      refresh_r <= in_refresh_time;
      now_r     <= in_now_time;
      elapsed_r <= in_elapsed_time;
    end
    cmp_idx_r       <= cnt_r;
    best_idx_r      <= best_idx_nxt;
    best_dl_r       <= best_dl_nxt;
    best_ord_r      <= best_ord_nxt;
    out_status_r    <= out_status_nxt;
    out_poll_slot_r <= out_poll_slot_nxt;
    out_wait_r      <= out_wait_nxt;
    out_overrun_r   <= out_overrun_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_poll_slot = out_poll_slot_r;
  assign out_wait_time = out_wait_r;
  assign out_overrun   = out_overrun_r;

endmodule

// ----- design/ppsch_chk.sv -----
// Port-level checker for the periodic poll scheduler, bound to the top level.
// Depends on ppsch_pkg and periodic_poll_scheduler.
module ppsch_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [ppsch_pkg::STATUS_W-1:0] out_status,
  input logic [ppsch_pkg::SLOT_W-1:0]   out_poll_slot,
  input logic                           out_overrun
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word shown while busy");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result words in consecutive cycles");

  a_overrun_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overrun) |->
      (out_status == ppsch_pkg::ST_SCHEDULED || out_status == ppsch_pkg::ST_IGNORED ||
       out_status == ppsch_pkg::ST_REFUSED))
    else $error("overrun flagged on a non poll_done status");

  a_poll_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ppsch_pkg::ST_POLL_NOW) |-> (out_poll_slot == '0))
    else $error("poll slot nonzero without poll now status");

endmodule

bind periodic_poll_scheduler ppsch_chk u_ppsch_chk (.*);
